/* hw/rtl/in_place_shuffle_unit_macros.svh */
// assertion macros for the in-place shuffle unit
`ifndef IN_PLACE_SHUFFLE_UNIT_MACROS_SVH
`define IN_PLACE_SHUFFLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define IPS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ips assertion failed");

// condition must never be true outside reset
`define IPS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("ips forbidden condition seen");

`else

`define IPS_ASSERT(lbl, clk, rst_n, prop)
`define IPS_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* hw/rtl/ips_pkg.sv */
// types and constants shared by the in-place shuffle unit
package ips_pkg;

	localparam int WORD_W    = 32;
	localparam int DIV_CNT_W = 6;

	typedef struct packed {
		logic signed [WORD_W-1:0] key_value;
		logic [WORD_W-1:0]        random_word;
		logic                     last_key;
	} ips_in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] shuffled_key;
		logic                     last_out;
		logic                     truncated;
	} ips_out_t;

	typedef struct packed {
		logic store;
		logic rd_word;
		logic div_load;
		logic rd_keys;
		logic wr_i;
		logic wr_j;
		logic emit;
		logic idx_inc;
		logic idx_clr;
		logic close;
	} ips_cmd_t;

	typedef struct packed {
		logic empty;
		logic div_done;
		logic last_step;
		logic emit_last;
	} ips_sts_t;

endpackage

/* hw/rtl/ips_mod.sv */
// bit-serial restoring modulo unit, one dividend bit per cycle
`include "in_place_shuffle_unit_macros.svh"

module ips_mod #(
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [ips_pkg::WORD_W-1:0] dividend,
	input  logic [CW-1:0]              divisor,
	output logic [AW-1:0]              rem,
	output logic                       done
);
	import ips_pkg::*;

	logic                 run_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    shreg_q;
	logic [AW-1:0]        rem_q;
	logic [CW-1:0]        div_q;
	logic [AW:0]          trial;
	logic [AW:0]          div_ext;
	logic                 fits;

	assign trial   = {rem_q, shreg_q[WORD_W-1]};
	assign div_ext = (AW+1)'(div_q);
	assign fits    = trial >= div_ext;
	assign rem     = rem_q;
	assign done    = run_q && (cnt_q == DIV_CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			cnt_q <= DIV_CNT_W'(WORD_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shreg_q <= dividend;
			rem_q   <= '0;
			div_q   <= divisor;
		end else if (run_q) begin
			shreg_q <= {shreg_q[WORD_W-2:0], 1'b0};
			if (fits) begin
				rem_q <= AW'(trial - div_ext);
			end else begin
				rem_q <= trial[AW-1:0];
			end
		end
	end

	// remainder left behind must lie below the divisor
	`IPS_ASSERT(a_rem_below_div, clk, arst_n, done |=> ((AW+1)'(rem_q) < div_ext))

endmodule

/* hw/rtl/ips_dp.sv */
// shuffle datapath: key and word stores, counters, modulo unit, result register
`include "in_place_shuffle_unit_macros.svh"

module ips_dp #(
	parameter int MAX_KEYS = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ips_pkg::ips_cmd_t  cmd,
	input  ips_pkg::ips_in_t   in_item,
	output ips_pkg::ips_sts_t  sts,
	output logic               result_valid,
	output ips_pkg::ips_out_t  result
);
	import ips_pkg::*;

	logic [WORD_W-1:0] key_mem [MAX_KEYS];
	logic [WORD_W-1:0] word_mem [MAX_KEYS];

	logic [CW-1:0]     fill_q;
	logic              ovf_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     j_q;
	logic [WORD_W-1:0] wrd_q;
	logic [WORD_W-1:0] rda_q;
	logic [WORD_W-1:0] rdb_q;
	logic              emit_s1;
	logic              last_s1;
	logic              trunc_s1;

	logic              full;
	logic [CW-1:0]     span;
	logic [AW-1:0]     mod_rem;
	logic              mod_done;
	logic [AW-1:0]     j_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	assign full   = fill_q == CW'(MAX_KEYS);
	assign span   = fill_q - CW'(idx_q);
	assign j_addr = idx_q + mod_rem;

	assign sts.empty     = fill_q == '0;
	assign sts.div_done  = mod_done;
	assign sts.last_step = ((CW+1)'(idx_q) + (CW+1)'(2)) == (CW+1)'(fill_q);
	assign sts.emit_last = (CW'(idx_q) + CW'(1)) == fill_q;

	ips_mod #(
		.AW(AW),
		.CW(CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.dividend (wrd_q),
		.divisor  (span),
		.rem      (mod_rem),
		.done     (mod_done)
	);

	// single write port on the key store
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q[AW-1:0];
		wr_data = in_item.key_value;
		if (cmd.store && !full) begin
			wr_en = 1'b1;
		end else if (cmd.wr_i) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
			wr_data = rdb_q;
		end else if (cmd.wr_j) begin
			wr_en   = 1'b1;
			wr_addr = j_q;
			wr_data = rda_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_data;
		end
		if (cmd.store && !full) begin
			word_mem[fill_q[AW-1:0]] <= in_item.random_word;
		end
		if (cmd.rd_word) begin
			wrd_q <= word_mem[idx_q];
		end
		if (cmd.rd_keys || cmd.emit) begin
			rda_q <= key_mem[idx_q];
		end
		if (cmd.rd_keys) begin
			rdb_q <= key_mem[j_addr];
			j_q   <= j_addr;
		end
		if (cmd.emit) begin
			last_s1  <= sts.emit_last;
			trunc_s1 <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
			emit_s1 <= 1'b0;
		end else begin
			emit_s1 <= cmd.emit;
			if (cmd.close) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
				idx_q  <= '0;
			end else begin
				if (cmd.store) begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						fill_q <= fill_q + CW'(1);
					end
				end
				if (cmd.idx_clr) begin
					idx_q <= '0;
				end else if (cmd.idx_inc) begin
					idx_q <= idx_q + AW'(1);
				end
			end
		end
	end

	assign result_valid        = emit_s1;
	assign result.shuffled_key = rda_q;
	assign result.last_out     = last_s1;
	assign result.truncated    = trunc_s1;

	// the fill count never passes capacity
	`IPS_ASSERT_NEVER(a_fill_range, clk, arst_n, fill_q > CW'(MAX_KEYS))
	// a final result is never followed straight away by another result
	`IPS_ASSERT(a_last_ends_burst, clk, arst_n, (emit_s1 && last_s1) |=> !emit_s1)

endmodule

/* hw/rtl/ips_ctrl.sv */
// shuffle controller: load, per-position shuffle sequence, emit
`include "in_place_shuffle_unit_macros.svh"

module ips_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_key,
	input  ips_pkg::ips_sts_t sts,
	output ips_pkg::ips_cmd_t cmd,
	output logic              busy
);
	import ips_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_WORD,
		ST_DIV_LOAD,
		ST_DIV,
		ST_RD_KEYS,
		ST_WR_I,
		ST_WR_J,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   busy_q;

	assign busy = busy_q;

	always_comb begin
		cmd          = '0;
		cmd.store    = (state_q == ST_IDLE) && start;
		cmd.rd_word  = state_q == ST_RD_WORD;
		cmd.div_load = state_q == ST_DIV_LOAD;
		cmd.rd_keys  = state_q == ST_RD_KEYS;
		cmd.wr_i     = state_q == ST_WR_I;
		cmd.wr_j     = state_q == ST_WR_J;
		cmd.emit     = state_q == ST_EMIT;
		case (state_q)
			ST_WR_J: begin
				cmd.idx_clr = sts.last_step;
				cmd.idx_inc = !sts.last_step;
			end
			ST_EMIT: begin
				cmd.close   = sts.emit_last;
				cmd.idx_inc = !sts.emit_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && last_key) begin
						state_q <= sts.empty ? ST_EMIT : ST_RD_WORD;
						busy_q  <= 1'b1;
					end
				end
				ST_RD_WORD:  state_q <= ST_DIV_LOAD;
				ST_DIV_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_RD_KEYS;
					end
				end
				ST_RD_KEYS:  state_q <= ST_WR_I;
				ST_WR_I:     state_q <= ST_WR_J;
				ST_WR_J: begin
					state_q <= sts.last_step ? ST_EMIT : ST_RD_WORD;
				end
				ST_EMIT: begin
					if (sts.emit_last) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// busy tracks every state except idle
	`IPS_ASSERT(a_busy_state, clk, arst_n, busy_q == (state_q != ST_IDLE))
	// a closing transaction always makes the unit busy
	`IPS_ASSERT(a_close_busy, clk, arst_n, (start && !busy_q && last_key) |=> busy_q)

endmodule

/* hw/rtl/in_place_shuffle_unit.sv */
// top level of the in-place shuffle unit (fisher-yates over a stored key set)
//
// channel  | handshake             | payload  | direction
// ---------+-----------------------+----------+----------
// input    | start high, busy low  | in_item  | in
// result   | result_valid strobe   | result   | out
//
// loading accepts a transaction whenever start is high while busy is low; busy stays
//   low until a transaction carrying last_key closes the set
// shuffling steps through each position i from 0 to len-2: word read, modulo
//   load, the bit-serial modulo unit, key reads, two key writes
//   through the single key store write port
// emitting then gives one result per cycle, len results, the last one marked
// reset clears the fill count, overflow flag, index, result strobe and controller only; the
//   stores need no clearing pass since only entries of the open set are read
// results cannot be stalled: each is on the ports for exactly one cycle
module in_place_shuffle_unit #(
	parameter int MAX_KEYS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ips_pkg::ips_in_t  in_item,
	output logic              result_valid,
	output ips_pkg::ips_out_t result
);
	import ips_pkg::*;

	// index width for the stores, count width for fill level and span
	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	ips_cmd_t cmd;
	ips_sts_t sts;

	// controller: sequences load, per-position shuffle and emit
	ips_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_key (in_item.last_key),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	// datapath: key and word stores, modulo unit, swap and result registers
	ips_dp #(
		.MAX_KEYS (MAX_KEYS),
		.AW       (AW),
		.CW       (CW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_item      (in_item),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
